>>> rtl/efc_pkg.sv
// Shared types, constants and digit helpers for the elevator floor controller.
// No dependencies; used by efc_scan and elevator_floor_controller.
`default_nettype none

package efc_pkg;

  localparam int REQ_W     = 20;  // call buttons / request bits
  localparam int FLOOR_W   = 5;
  localparam int TIMER_W   = 8;
  localparam int SEG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_TICKS = 1'b1;

  localparam logic [TIMER_W-1:0] MOVE_TICKS_RST = 8'd6;
  localparam logic [TIMER_W-1:0] DOOR_TICKS_RST = 8'd31;

  localparam logic [FLOOR_W-1:0] FLOOR_ONE = 5'd1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SCAN  = 3'd1,
    PH_MOVE  = 3'd2,
    PH_OPEN  = 3'd3,
    PH_CLOSE = 3'd4
  } phase_t;

  // result of the ascending request search
  typedef struct packed {
    logic               found;
    logic [FLOOR_W-1:0] floor;
  } scan_res_t;

  // gfedcba pattern of one decimal digit
  function automatic logic [SEG_W-1:0] seg7(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

  // tens digit of a floor number (at most 31)
  function automatic logic [1:0] tens_of(input logic [FLOOR_W-1:0] f);
    logic [1:0] t;
    if (f >= 5'd30)      t = 2'd3;
    else if (f >= 5'd20) t = 2'd2;
    else if (f >= 5'd10) t = 2'd1;
    else                 t = 2'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [FLOOR_W-1:0] f);
    logic [1:0]         t;
    logic [FLOOR_W-1:0] r;
    t = tens_of(f);
    r = f - (FLOOR_W'(t) * 5'd10);
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/elevator_floor_controller.sv
// Elevator floor controller: one display tick per input transfer, one status result each.
// The result of a tick is registered and offered in the cycle after its transfer.
// Throughput: one tick per cycle while the result stream is ready; a new tick is let in
// only when the output register is empty or its waiting result is taken in that cycle.
// Reset (rst_n low, synchronous): car at floor one, idle, no requests, timers default.
// Depends on efc_pkg and efc_scan.
`default_nettype none

module elevator_floor_controller #(
  parameter int FLOORS = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [efc_pkg::IN_W-1:0]         in_tdata,   // [19:0] button_mask
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [4:0] floor_now, [11:5] tens_segments, [18:12] ones_segments,
  // [19] door_open_drive, [20] door_close_drive, [21] moving
  output logic [efc_pkg::OUT_W-1:0]             out_tdata,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [efc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [efc_pkg::TIMER_W-1:0]      cfg_data
);

  localparam int REQ_W   = efc_pkg::REQ_W;
  localparam int FLOOR_W = efc_pkg::FLOOR_W;
  localparam int TIMER_W = efc_pkg::TIMER_W;
  localparam int NREQ    = (FLOORS < REQ_W) ? FLOORS : REQ_W;
  localparam logic [REQ_W-1:0] FLOOR_MASK = {REQ_W{1'b1}} >> (REQ_W - NREQ);

  // state
  logic [REQ_W-1:0]   requests_r,  requests_nxt;
  logic               pending_r,   pending_nxt;
  logic [FLOOR_W-1:0] car_floor_r, car_floor_nxt;
  efc_pkg::phase_t    phase_r,     phase_nxt;
  logic [FLOOR_W-1:0] scan_r,      scan_nxt;
  logic [TIMER_W-1:0] timer_r,     timer_nxt;
  logic [TIMER_W-1:0] move_ticks_r, door_ticks_r;

  logic               out_valid_r;
  logic [efc_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic take;

  // phase after the start-of-tick decisions
  efc_pkg::phase_t    ph_res;
  logic [FLOOR_W-1:0] scan_res;
  logic [TIMER_W-1:0] timer_res;
  logic               pending_res;
  logic [FLOOR_W-1:0] scan_from;
  efc_pkg::scan_res_t hit;

  logic [REQ_W-1:0]   buttons;
  logic [FLOOR_W-1:0] car_step;

  assign in_tready  = !out_valid_r || out_tready;
  assign take       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign buttons = in_tdata[REQ_W-1:0] & FLOOR_MASK;

  // a pending call starts a fresh pass from floor one
  assign scan_from = (phase_r == efc_pkg::PH_IDLE && pending_r) ? efc_pkg::FLOOR_ONE : scan_r;

  efc_scan u_scan (
    .requests   (requests_r),
    .scan_floor (scan_from),
    .res        (hit)
  );

  // decide the phase this tick runs in
  always_comb begin
    ph_res      = phase_r;
    scan_res    = scan_r;
    timer_res   = timer_r;
    pending_res = pending_r;
    if ((phase_r == efc_pkg::PH_IDLE && pending_r) || phase_r == efc_pkg::PH_SCAN) begin
      if (hit.found) begin
        scan_res = hit.floor;
        if (car_floor_r == hit.floor) begin
          pending_res = 1'b0;
          ph_res      = efc_pkg::PH_OPEN;
          timer_res   = door_ticks_r - 8'd1;
        end else begin
          ph_res    = efc_pkg::PH_MOVE;
          timer_res = move_ticks_r - 8'd1;
        end
      end else begin
        ph_res   = efc_pkg::PH_IDLE;
        scan_res = efc_pkg::FLOOR_ONE;
      end
    end
  end

  assign car_step = (car_floor_r > scan_res) ? car_floor_r - 5'd1 :
                    (car_floor_r < scan_res) ? car_floor_r + 5'd1 : car_floor_r;

  // next state
  always_comb begin
    requests_nxt  = requests_r;
    pending_nxt   = pending_res;
    car_floor_nxt = car_floor_r;
    phase_nxt     = ph_res;
    scan_nxt      = scan_res;
    timer_nxt     = timer_res;
    if (ph_res == efc_pkg::PH_IDLE) begin
      requests_nxt = requests_r | buttons;
      if (buttons != '0) pending_nxt = 1'b1;
    end else if (timer_res != '0) begin
      timer_nxt = timer_res - 8'd1;
    end else begin
      unique case (ph_res)
        efc_pkg::PH_MOVE: begin
          car_floor_nxt = car_step;
          if (car_step == scan_res) begin
            pending_nxt = 1'b0;
            phase_nxt   = efc_pkg::PH_OPEN;
            timer_nxt   = door_ticks_r - 8'd1;
          end else begin
            scan_nxt  = scan_res + 5'd1;
            phase_nxt = efc_pkg::PH_SCAN;
          end
        end
        efc_pkg::PH_OPEN: begin
          phase_nxt = efc_pkg::PH_CLOSE;
          timer_nxt = door_ticks_r - 8'd1;
        end
        efc_pkg::PH_CLOSE: begin
          for (int k = 0; k < REQ_W; k++) begin
            if (scan_res == FLOOR_W'(k + 1)) requests_nxt[k] = 1'b0;
          end
          scan_nxt  = scan_res + 5'd1;
          phase_nxt = efc_pkg::PH_SCAN;
        end
        default: ;  // idle and scan are settled above
      endcase
    end
  end

  // result fields
  always_comb begin
    out_data_nxt          = '0;
    out_data_nxt[4:0]     = car_floor_r;
    out_data_nxt[11:5]    = efc_pkg::seg7({2'b00, efc_pkg::tens_of(car_floor_r)});
    out_data_nxt[18:12]   = efc_pkg::seg7(efc_pkg::ones_of(car_floor_r));
    out_data_nxt[19]      = (ph_res == efc_pkg::PH_OPEN);
    out_data_nxt[20]      = (ph_res == efc_pkg::PH_CLOSE);
    out_data_nxt[21]      = (ph_res == efc_pkg::PH_MOVE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      requests_r   <= '0;
      pending_r    <= 1'b0;
      car_floor_r  <= efc_pkg::FLOOR_ONE;
      phase_r      <= efc_pkg::PH_IDLE;
      scan_r       <= efc_pkg::FLOOR_ONE;
      timer_r      <= '0;
      move_ticks_r <= efc_pkg::MOVE_TICKS_RST;
      door_ticks_r <= efc_pkg::DOOR_TICKS_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        requests_r  <= requests_nxt;
        pending_r   <= pending_nxt;
        car_floor_r <= car_floor_nxt;
        phase_r     <= phase_nxt;
        scan_r      <= scan_nxt;
        timer_r     <= timer_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          efc_pkg::CFG_MOVE_TICKS: move_ticks_r <= cfg_data;
          efc_pkg::CFG_DOOR_TICKS: door_ticks_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/efc_scan.sv
// Ascending search for the lowest requested floor at or above the scan floor.
// Depends on efc_pkg.
`default_nettype none

module efc_scan (
  input  wire logic [efc_pkg::REQ_W-1:0]   requests,
  input  wire logic [efc_pkg::FLOOR_W-1:0] scan_floor,
  output efc_pkg::scan_res_t               res
);

  always_comb begin
    res.found = 1'b0;
    res.floor = efc_pkg::FLOOR_ONE;
    // walk downwards so that the lowest candidate is the one left standing
    for (int k = efc_pkg::REQ_W - 1; k >= 0; k--) begin
      if (requests[k] && (scan_floor != '0) &&
          (scan_floor <= efc_pkg::FLOOR_W'(k + 1))) begin
        res.found = 1'b1;
        res.floor = efc_pkg::FLOOR_W'(k + 1);
      end
    end
  end

endmodule

`default_nettype wire
